// ===== rtl/sdp_pkg.sv =====
package sdp_pkg;

  localparam int unsigned FracBits = 16;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned AccWidth = ValueWidth + 8;

  localparam logic [ValueWidth-1:0] One = 32'h0001_0000;
  localparam logic [15:0] SplineC = 16'd29816;
  localparam logic [61:0] WideMax = '1;
  localparam logic [AccWidth-1:0] AccMax = '1;
  localparam logic [ValueWidth-1:0] ValueMax = '1;

  localparam logic [ValueWidth-1:0] RstSmoothing = 32'h0001_0000;
  localparam logic [ValueWidth-1:0] RstMass = 32'h0001_0000;
  localparam logic [ValueWidth-1:0] RstRestDensity = 32'd65536000;
  localparam logic [ValueWidth-1:0] RstStiffness = 32'h0001_0000;
  localparam logic [2:0] RstExponent = 3'd7;

  typedef struct packed {
    logic signed [ValueWidth-1:0] self_x;
    logic signed [ValueWidth-1:0] self_y;
    logic signed [ValueWidth-1:0] nbr_x;
    logic signed [ValueWidth-1:0] nbr_y;
    logic                         nbr_solid;
    logic                         has_neighbor;
    logic                         last_neighbor;
  } sdp_in_t;

  typedef struct packed {
    logic [ValueWidth-1:0] density;
    logic [ValueWidth-1:0] pressure;
    logic                  saturated;
  } sdp_out_t;

  typedef enum logic [2:0] {
    CFG_SMOOTHING = 3'd0,
    CFG_FLUID_MASS = 3'd1,
    CFG_SOLID_MASS = 3'd2,
    CFG_REST_DENSITY = 3'd3,
    CFG_STIFFNESS = 3'd4,
    CFG_EXPONENT = 3'd5
  } sdp_cfg_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DIFF,
    ST_QX,
    ST_QY,
    ST_MX,
    ST_MY,
    ST_SQRT,
    ST_P1,
    ST_P2,
    ST_SH,
    ST_TM,
    ST_D1,
    ST_D2,
    ST_ACC,
    ST_LAST,
    ST_RATIO,
    ST_POW,
    ST_PMUL,
    ST_KMUL,
    ST_KW,
    ST_OUT
  } sdp_state_e;

endpackage

// ===== rtl/sdp_mul.sv =====
module sdp_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic        done_o,
  output logic [79:0] prod_o,
  output logic        ovf_o
);

  logic [63:0] a_q, b_q;
  logic [79:0] acc_q;
  logic        ovf_q, busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [81:0] sum;

  assign sum = {1'b0, acc_q, 1'b0} + (b_q[63] ? {18'b0, a_q} : 82'b0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
      ovf_q <= 1'b0;
    end else if (busy_q) begin
      acc_q <= sum[79:0];
      ovf_q <= ovf_q | (|sum[81:80]);
      b_q   <= {b_q[62:0], 1'b0};
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
  assign ovf_o  = ovf_q;

endmodule

// ===== rtl/sdp_div.sv =====
module sdp_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] x_i,
  input  logic [31:0] d_i,
  output logic        done_o,
  output logic [63:0] quo_o,
  output logic        dz_o
);

  logic [63:0] n_q, quo_q;
  logic [31:0] d_q, rem_q;
  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [32:0] rem_sh, rem_sub;
  logic        ge;

  assign rem_sh  = {rem_q, n_q[63]};
  assign ge      = rem_sh >= {1'b0, d_q};
  assign rem_sub = rem_sh - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 7'd64;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 7'd1;
        if (cnt_q == 7'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q   <= {x_i, 16'b0};
      d_q   <= d_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      n_q   <= {n_q[62:0], 1'b0};
      rem_q <= ge ? rem_sub[31:0] : rem_sh[31:0];
      quo_q <= {quo_q[62:0], ge};
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;
  assign dz_o   = (d_q == 32'd0);

endmodule

// ===== rtl/sdp_sqrt.sv =====
module sdp_sqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [35:0] v_i,
  output logic        done_o,
  output logic [17:0] res_o
);

  logic [35:0] v_q, res_q, bit_q, trial;
  logic        busy_q, done_q;
  logic [4:0]  cnt_q;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd18;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == 5'd1) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q   <= v_i;
      res_q <= '0;
      bit_q <= 36'h4_0000_0000;
    end else if (busy_q) begin
      if (v_q >= trial) begin
        v_q   <= v_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q[17:0];

endmodule

// ===== rtl/sph_density_pressure_unit.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | in_valid_i / in_ready_o  | in_data_i  (sdp_in_t)
// out     | output    | out_valid_o / out_ready_i| out_data_o (sdp_out_t)
// cfg     | input     | cfg_we_i                 | cfg_addr_i, cfg_wdata_i
// A neighbour transaction runs four 64-step divisions, six 64-step multiplications
// and an 18-step square root, one unit busy at a time.
// A last transaction adds one division and up to eight multiplications.
// Reset clears the sequencer, the running sum and the configuration registers to their defaults.
// A result waiting in the output register stalls only the next last transaction.
module sph_density_pressure_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sdp_pkg::sdp_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output sdp_pkg::sdp_out_t out_data_o,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_addr_i,
  input  logic [31:0]       cfg_wdata_i
);

  sdp_pkg::sdp_state_e state_q, state_d;
  sdp_pkg::sdp_in_t    in_q;
  sdp_pkg::sdp_out_t   out_q, out_d;
  logic out_valid_q, out_valid_d;

  logic [31:0] h_q, fmass_q, smass_q, rho0_q, k_q;
  logic [2:0]  exp_q;

  logic [39:0] acc_q, acc_d, term_q, term_d;
  logic [16:0] qx_q, qx_d, qy_q, qy_d, base_q, base_d, x2_q, x2_d;
  logic [34:0] sq_q, sq_d;
  logic        inner_q, inner_d;
  logic [31:0] dens_q, dens_d;
  logic [31:0] pres_q, pres_d;
  logic [47:0] ratio_q, ratio_d;
  logic [61:0] p_q, p_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        povf_q, povf_d, sat_q, sat_d;

  logic        mul_start, mul_done, mul_ovf;
  logic [63:0] mul_a, mul_b;
  logic [79:0] mul_prod;
  logic        div_start, div_done, div_dz;
  logic [47:0] div_x;
  logic [31:0] div_d;
  logic [63:0] div_quo;
  logic        sq_start, sq_done;
  logic [35:0] sq_v;
  logic [17:0] sq_res;

  logic signed [32:0] ddx, ddy;
  logic [32:0] dx, dy, h2;
  logic [16:0] x3;
  logic signed [19:0] poly;
  logic [16:0] fval;
  logic [40:0] acc_sum;
  logic [63:0] mfrac;
  logic [39:0] dmax;

  sdp_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b),
    .done_o(mul_done), .prod_o(mul_prod), .ovf_o(mul_ovf)
  );

  sdp_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .x_i(div_x), .d_i(div_d),
    .done_o(div_done), .quo_o(div_quo), .dz_o(div_dz)
  );

  sdp_sqrt u_sqrt (
    .clk_i, .rst_ni, .start_i(sq_start), .v_i(sq_v),
    .done_o(sq_done), .res_o(sq_res)
  );

  assign ddx   = {in_q.self_x[31], in_q.self_x} - {in_q.nbr_x[31], in_q.nbr_x};
  assign ddy   = {in_q.self_y[31], in_q.self_y} - {in_q.nbr_y[31], in_q.nbr_y};
  assign dx    = ddx[32] ? 33'(-ddx) : 33'(ddx);
  assign dy    = ddy[32] ? 33'(-ddy) : 33'(ddy);
  assign h2    = {h_q, 1'b0};
  assign x3    = mul_prod[32:16];
  assign poly  = 20'sd65536 - signed'(20'(({3'b0, x2_q} * 20'd3) >> 1))
               + signed'(20'(({3'b0, x3} * 20'd3) >> 2));
  assign mfrac = mul_prod[79:16];
  assign acc_sum = {1'b0, acc_q} + {1'b0, term_q};
  assign dmax  = (acc_q < {8'b0, rho0_q}) ? {8'b0, rho0_q} : acc_q;

  always_comb begin
    state_d     = state_q;
    acc_d       = acc_q;
    term_d      = term_q;
    qx_d        = qx_q;
    qy_d        = qy_q;
    sq_d        = sq_q;
    base_d      = base_q;
    x2_d        = x2_q;
    inner_d     = inner_q;
    dens_d      = dens_q;
    pres_d      = pres_q;
    ratio_d     = ratio_q;
    p_d         = p_q;
    cnt_d       = cnt_q;
    povf_d      = povf_q;
    sat_d       = sat_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mul_start   = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    div_start   = 1'b0;
    div_x       = '0;
    div_d       = h_q;
    sq_start    = 1'b0;
    sq_v        = '0;
    fval        = '0;
    in_ready_o  = 1'b0;
    case (state_q)
      sdp_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = in_data_i.has_neighbor ? sdp_pkg::ST_DIFF : sdp_pkg::ST_LAST;
        end
      end
      sdp_pkg::ST_DIFF: begin
        if (dx >= h2 || dy >= h2) begin
          term_d  = '0;
          state_d = sdp_pkg::ST_ACC;
        end else begin
          div_start = 1'b1;
          div_x     = {15'b0, dx};
          state_d   = sdp_pkg::ST_QX;
        end
      end
      sdp_pkg::ST_QX: begin
        if (div_done) begin
          qx_d      = div_quo[16:0];
          div_start = 1'b1;
          div_x     = {15'b0, dy};
          state_d   = sdp_pkg::ST_QY;
        end
      end
      sdp_pkg::ST_QY: begin
        if (div_done) begin
          qy_d      = div_quo[16:0];
          mul_start = 1'b1;
          mul_a     = {47'b0, qx_q};
          mul_b     = {47'b0, qx_q};
          state_d   = sdp_pkg::ST_MX;
        end
      end
      sdp_pkg::ST_MX: begin
        if (mul_done) begin
          sq_d      = mul_prod[34:0];
          mul_start = 1'b1;
          mul_a     = {47'b0, qy_q};
          mul_b     = {47'b0, qy_q};
          state_d   = sdp_pkg::ST_MY;
        end
      end
      sdp_pkg::ST_MY: begin
        if (mul_done) begin
          sq_start = 1'b1;
          sq_v     = {1'b0, sq_q} + mul_prod[35:0];
          state_d  = sdp_pkg::ST_SQRT;
        end
      end
      sdp_pkg::ST_SQRT: begin
        if (sq_done) begin
          if (sq_res >= 18'h2_0000) begin
            term_d  = '0;
            state_d = sdp_pkg::ST_ACC;
          end else begin
            inner_d   = sq_res <= 18'h1_0000;
            base_d    = (sq_res <= 18'h1_0000) ? sq_res[16:0]
                                               : 17'(18'h2_0000 - sq_res);
            mul_start = 1'b1;
            mul_a     = {47'b0, base_d};
            mul_b     = {47'b0, base_d};
            state_d   = sdp_pkg::ST_P1;
          end
        end
      end
      sdp_pkg::ST_P1: begin
        if (mul_done) begin
          x2_d      = mul_prod[32:16];
          mul_start = 1'b1;
          mul_a     = {47'b0, mul_prod[32:16]};
          mul_b     = {47'b0, base_q};
          state_d   = sdp_pkg::ST_P2;
        end
      end
      sdp_pkg::ST_P2: begin
        if (mul_done) begin
          if (inner_q) begin
            fval = poly[19] ? 17'd0 : poly[16:0];
          end else begin
            fval = x3 >> 2;
          end
          mul_start = 1'b1;
          mul_a     = {47'b0, fval};
          mul_b     = {48'b0, sdp_pkg::SplineC};
          state_d   = sdp_pkg::ST_SH;
        end
      end
      sdp_pkg::ST_SH: begin
        if (mul_done) begin
          mul_start = 1'b1;
          mul_a     = {32'b0, (in_q.nbr_solid ? smass_q : fmass_q)};
          mul_b     = {48'b0, mul_prod[31:16]};
          state_d   = sdp_pkg::ST_TM;
        end
      end
      sdp_pkg::ST_TM: begin
        if (mul_done) begin
          div_start = 1'b1;
          div_x     = mul_prod[63:16];
          state_d   = sdp_pkg::ST_D1;
        end
      end
      sdp_pkg::ST_D1: begin
        if (div_done) begin
          div_start = 1'b1;
          div_x     = div_quo[47:0];
          state_d   = sdp_pkg::ST_D2;
        end
      end
      sdp_pkg::ST_D2: begin
        if (div_done) begin
          term_d  = (div_quo > {24'b0, sdp_pkg::AccMax}) ? sdp_pkg::AccMax : div_quo[39:0];
          state_d = sdp_pkg::ST_ACC;
        end
      end
      sdp_pkg::ST_ACC: begin
        acc_d   = acc_sum[40] ? sdp_pkg::AccMax : acc_sum[39:0];
        state_d = sdp_pkg::ST_LAST;
      end
      sdp_pkg::ST_LAST: begin
        if (!in_q.last_neighbor) begin
          state_d = sdp_pkg::ST_IDLE;
        end else begin
          sat_d     = |dmax[39:32];
          dens_d    = (|dmax[39:32]) ? sdp_pkg::ValueMax : dmax[31:0];
          div_start = 1'b1;
          div_x     = {16'b0, dens_d};
          div_d     = rho0_q;
          state_d   = sdp_pkg::ST_RATIO;
        end
      end
      sdp_pkg::ST_RATIO: begin
        if (div_done) begin
          ratio_d = div_quo[47:0];
          povf_d  = div_dz;
          p_d     = {30'b0, sdp_pkg::One};
          cnt_d   = '0;
          state_d = sdp_pkg::ST_POW;
        end
      end
      sdp_pkg::ST_POW: begin
        if (cnt_q < exp_q) begin
          mul_start = 1'b1;
          mul_a     = {2'b0, p_q};
          mul_b     = {16'b0, ratio_q};
          state_d   = sdp_pkg::ST_PMUL;
        end else begin
          state_d = sdp_pkg::ST_KMUL;
        end
      end
      sdp_pkg::ST_PMUL: begin
        if (mul_done) begin
          if (mul_ovf || mfrac > {2'b0, sdp_pkg::WideMax}) begin
            p_d    = sdp_pkg::WideMax;
            povf_d = 1'b1;
          end else begin
            p_d = mfrac[61:0];
          end
          cnt_d   = cnt_q + 3'd1;
          state_d = sdp_pkg::ST_POW;
        end
      end
      sdp_pkg::ST_KMUL: begin
        if (povf_q) begin
          pres_d  = (k_q != 32'd0) ? sdp_pkg::ValueMax : 32'd0;
          sat_d   = sat_q | (k_q != 32'd0);
          state_d = sdp_pkg::ST_OUT;
        end else begin
          mul_start = 1'b1;
          mul_a     = {32'b0, k_q};
          mul_b     = (p_q > {30'b0, sdp_pkg::One}) ? {2'b0, p_q - {30'b0, sdp_pkg::One}}
                                                  : 64'd0;
          state_d   = sdp_pkg::ST_KW;
        end
      end
      sdp_pkg::ST_KW: begin
        if (mul_done) begin
          if (mul_ovf || (|mfrac[63:32])) begin
            pres_d = sdp_pkg::ValueMax;
            sat_d  = 1'b1;
          end else begin
            pres_d = mfrac[31:0];
          end
          state_d = sdp_pkg::ST_OUT;
        end
      end
      sdp_pkg::ST_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d.density   = dens_q;
          out_d.pressure  = pres_q;
          out_d.saturated = sat_q;
          out_valid_d     = 1'b1;
          acc_d           = '0;
          state_d         = sdp_pkg::ST_IDLE;
        end
      end
      default: state_d = sdp_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
      h_q         <= sdp_pkg::RstSmoothing;
      fmass_q     <= sdp_pkg::RstMass;
      smass_q     <= sdp_pkg::RstMass;
      rho0_q      <= sdp_pkg::RstRestDensity;
      k_q         <= sdp_pkg::RstStiffness;
      exp_q       <= sdp_pkg::RstExponent;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
      if (cfg_we_i) begin
        case (cfg_addr_i)
          sdp_pkg::CFG_SMOOTHING:    h_q     <= cfg_wdata_i;
          sdp_pkg::CFG_FLUID_MASS:   fmass_q <= cfg_wdata_i;
          sdp_pkg::CFG_SOLID_MASS:   smass_q <= cfg_wdata_i;
          sdp_pkg::CFG_REST_DENSITY: rho0_q  <= cfg_wdata_i;
          sdp_pkg::CFG_STIFFNESS:    k_q     <= cfg_wdata_i;
          sdp_pkg::CFG_EXPONENT:     exp_q   <= cfg_wdata_i[2:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    out_q   <= out_d;
    term_q  <= term_d;
    qx_q    <= qx_d;
    qy_q    <= qy_d;
    sq_q    <= sq_d;
    base_q  <= base_d;
    x2_q    <= x2_d;
    inner_q <= inner_d;
    dens_q  <= dens_d;
    pres_q  <= pres_d;
    ratio_q <= ratio_d;
    p_q     <= p_d;
    cnt_q   <= cnt_d;
    povf_q  <= povf_d;
    sat_q   <= sat_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("accepted while busy");
  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !$past(out_valid_o)) |-> $past(state_q == sdp_pkg::ST_OUT))
    else $error("result without output step");
  a_sum_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sdp_pkg::ST_OUT && state_d == sdp_pkg::ST_IDLE) |=> (acc_q == '0))
    else $error("sum not cleared");
`endif

endmodule

// ===== tb/tb.sv =====
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned LimitCycles = 20000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  sdp_pkg::sdp_in_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  sdp_pkg::sdp_out_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_addr_i = '0;
  logic [31:0] cfg_wdata_i = '0;

  sph_density_pressure_unit dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  logic [63:0] h_q, fmass_q, smass_q, rho0_q, k_q;
  logic [2:0] gam_q;
  logic [63:0] sum_q;

  sdp_pkg::sdp_in_t nbr_queue[$];
  sdp_pkg::sdp_out_t result_queue[$];
  int send_idle_pct, recv_idle_pct;
  int errors;
  longint unsigned cycles;

  function automatic logic [63:0] frac_div(logic [63:0] x, logic [63:0] d, logic [63:0] cap,
                                           inout bit ovf);
    logic [127:0] q;
    if (d == 0) begin
      ovf = 1;
      return cap;
    end
    q = ({64'd0, x} << sdp_pkg::FracBits) / {64'd0, d};
    if (q > {64'd0, cap}) begin
      ovf = 1;
      return cap;
    end
    return q[63:0];
  endfunction

  function automatic logic [63:0] frac_mul(logic [63:0] a, logic [63:0] b, logic [63:0] cap,
                                           inout bit ovf);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> sdp_pkg::FracBits;
    if (p > {64'd0, cap}) begin
      ovf = 1;
      return cap;
    end
    return p[63:0];
  endfunction

  function automatic logic [63:0] int_sqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] abs_gap(logic signed [31:0] a, logic signed [31:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return d < 0 ? -d : d;
  endfunction

  function automatic logic [63:0] kernel_term(sdp_pkg::sdp_in_t it);
    logic [63:0] dx, dy, qx, qy, q, f, shape, t, q2, q3, d, d2, m;
    longint s;
    bit ovf;
    ovf = 0;
    m = it.nbr_solid ? smass_q : fmass_q;
    dx = abs_gap(it.self_x, it.nbr_x);
    dy = abs_gap(it.self_y, it.nbr_y);
    if (dx >= 2 * h_q || dy >= 2 * h_q) return 0;
    qx = frac_div(dx, h_q, sdp_pkg::WideMax, ovf);
    qy = frac_div(dy, h_q, sdp_pkg::WideMax, ovf);
    q = int_sqrt(qx * qx + qy * qy);
    if (q >= 2 * sdp_pkg::One) return 0;
    if (q <= sdp_pkg::One) begin
      q2 = (q * q) >> sdp_pkg::FracBits;
      q3 = (q2 * q) >> sdp_pkg::FracBits;
      s = longint'(sdp_pkg::One) - longint'((3 * q2) >> 1) + longint'((3 * q3) >> 2);
      f = s < 0 ? 0 : s;
    end else begin
      d = 2 * sdp_pkg::One - q;
      d2 = (d * d) >> sdp_pkg::FracBits;
      f = ((d2 * d) >> sdp_pkg::FracBits) >> 2;
    end
    shape = (f * sdp_pkg::SplineC) >> sdp_pkg::FracBits;
    t = frac_mul(m, shape, sdp_pkg::WideMax, ovf);
    t = frac_div(t, h_q, sdp_pkg::WideMax, ovf);
    return frac_div(t, h_q, sdp_pkg::AccMax, ovf);
  endfunction

  task automatic predict_particle(sdp_pkg::sdp_in_t it);
    logic [63:0] t, dens, ratio, p, pres;
    bit sat, povf, kovf;
    sdp_pkg::sdp_out_t r;
    sat = 0;
    povf = 0;
    kovf = 0;
    if (it.has_neighbor) begin
      t = kernel_term(it);
      sum_q = (t > sdp_pkg::AccMax - sum_q) ? sdp_pkg::AccMax : sum_q + t;
    end
    if (!it.last_neighbor) return;
    dens = sum_q < rho0_q ? rho0_q : sum_q;
    if (dens > sdp_pkg::ValueMax) begin
      dens = sdp_pkg::ValueMax;
      sat = 1;
    end
    ratio = frac_div(dens, rho0_q, sdp_pkg::WideMax, povf);
    p = sdp_pkg::One;
    for (int i = 0; i < gam_q; i++) p = frac_mul(p, ratio, sdp_pkg::WideMax, povf);
    if (povf && k_q != 0) begin
      pres = sdp_pkg::ValueMax;
      sat = 1;
    end else if (povf) begin
      pres = 0;
    end else begin
      pres = frac_mul(k_q, p > sdp_pkg::One ? p - sdp_pkg::One : 0, sdp_pkg::ValueMax, kovf);
      if (kovf) sat = 1;
    end
    r.density = dens[31:0];
    r.pressure = pres[31:0];
    r.saturated = sat;
    result_queue.push_back(r);
    sum_q = 0;
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predict_particle(in_data_i);
      end
      if (!in_valid_i || in_ready_o) begin
        if (nbr_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data_i <= nbr_queue.pop_front();
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    sdp_pkg::sdp_out_t e;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (result_queue.size() == 0) begin
          $error("unexpected result density=%h", out_data_o.density);
          errors++;
        end else begin
          e = result_queue.pop_front();
          if (out_data_o.density !== e.density) begin
            $error("density expected %h actual %h", e.density, out_data_o.density);
            errors++;
          end
          if (out_data_o.pressure !== e.pressure) begin
            $error("pressure expected %h actual %h", e.pressure, out_data_o.pressure);
            errors++;
          end
          if (out_data_o.saturated !== e.saturated) begin
            $error("saturated expected %b actual %b", e.saturated, out_data_o.saturated);
            errors++;
          end
        end
      end
      out_ready_i <= $urandom_range(99) >= recv_idle_pct;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LimitCycles) begin
      $display("sph_density_pressure_unit test failed");
      $finish;
    end
  end

  task automatic write_reg(sdp_pkg::sdp_cfg_e idx, logic [31:0] v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      sdp_pkg::CFG_SMOOTHING: h_q = v;
      sdp_pkg::CFG_FLUID_MASS: fmass_q = v;
      sdp_pkg::CFG_SOLID_MASS: smass_q = v;
      sdp_pkg::CFG_REST_DENSITY: rho0_q = v;
      sdp_pkg::CFG_STIFFNESS: k_q = v;
      default: gam_q = v[2:0];
    endcase
  endtask

  task automatic drain();
    while (nbr_queue.size() != 0 || in_valid_i || result_queue.size() != 0) @(posedge clk_i);
    repeat (700) @(posedge clk_i);
  endtask

  function automatic sdp_pkg::sdp_in_t make_nbr(logic [63:0] h, bit last);
    sdp_pkg::sdp_in_t it;
    logic [31:0] span;
    it.self_x = $urandom;
    it.self_y = $urandom;
    span = (h > 32'h3fff_ffff) ? 32'h7fff_ffff : h[31:0] * 2 + 2;
    case ($urandom_range(3))
      0: begin
        it.nbr_x = $urandom;
        it.nbr_y = $urandom;
      end
      default: begin
        it.nbr_x = it.self_x + $signed($urandom_range(span)) - $signed(span >> 1);
        it.nbr_y = it.self_y + $signed($urandom_range(span)) - $signed(span >> 1);
      end
    endcase
    it.nbr_solid = $urandom_range(1);
    it.has_neighbor = $urandom_range(9) != 0;
    it.last_neighbor = last;
    return it;
  endfunction

  task automatic random_particles(int n);
    int k;
    for (int i = 0; i < n; i += k) begin
      k = $urandom_range(1, 8);
      for (int j = 0; j < k; j++) nbr_queue.push_back(make_nbr(h_q, j == k - 1));
    end
  endtask

  initial begin
    sdp_pkg::sdp_in_t it;
    errors = 0;
    cycles = 0;
    h_q = sdp_pkg::RstSmoothing;
    fmass_q = sdp_pkg::RstMass;
    smass_q = sdp_pkg::RstMass;
    rho0_q = sdp_pkg::RstRestDensity;
    k_q = sdp_pkg::RstStiffness;
    gam_q = sdp_pkg::RstExponent;
    sum_q = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    write_reg(sdp_pkg::CFG_REST_DENSITY, 32'h0001_0000);
    it = '0;
    it.has_neighbor = 1'b1;
    it.last_neighbor = 1'b1;
    nbr_queue.push_back(it);
    it.nbr_x = 32'h0000_8000;
    it.nbr_solid = 1'b1;
    nbr_queue.push_back(it);
    it.nbr_x = 32'h0001_8000;
    nbr_queue.push_back(it);
    it.nbr_x = 32'h0002_0000;
    nbr_queue.push_back(it);
    it.self_x = 32'h8000_0000;
    it.nbr_x = 32'h7fff_ffff;
    it.self_y = 32'h7fff_ffff;
    it.nbr_y = 32'h8000_0000;
    nbr_queue.push_back(it);
    it = '0;
    it.last_neighbor = 1'b1;
    nbr_queue.push_back(it);
    it.has_neighbor = 1'b1;
    it.last_neighbor = 1'b0;
    nbr_queue.push_back(it);
    nbr_queue.push_back(it);
    it.last_neighbor = 1'b1;
    nbr_queue.push_back(it);
    drain();

    write_reg(sdp_pkg::CFG_SMOOTHING, 32'd1);
    write_reg(sdp_pkg::CFG_FLUID_MASS, 32'hffff_ffff);
    write_reg(sdp_pkg::CFG_SOLID_MASS, 32'hffff_ffff);
    write_reg(sdp_pkg::CFG_STIFFNESS, 32'hffff_ffff);
    write_reg(sdp_pkg::CFG_EXPONENT, 3'd1);
    it = '0;
    it.has_neighbor = 1'b1;
    repeat (3) nbr_queue.push_back(it);
    it.last_neighbor = 1'b1;
    nbr_queue.push_back(it);
    drain();
    write_reg(sdp_pkg::CFG_SMOOTHING, 32'hffff_ffff);
    write_reg(sdp_pkg::CFG_REST_DENSITY, 32'hffff_ffff);
    write_reg(sdp_pkg::CFG_EXPONENT, 3'd7);
    write_reg(sdp_pkg::CFG_STIFFNESS, 32'd0);
    it.nbr_x = 32'h7fff_ffff;
    nbr_queue.push_back(it);
    drain();
    write_reg(sdp_pkg::CFG_REST_DENSITY, 32'd1);
    nbr_queue.push_back(it);
    it.nbr_x = '0;
    nbr_queue.push_back(it);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin
          send_idle_pct = 23;
          recv_idle_pct = 57;
        end
        1: begin
          send_idle_pct = 57;
          recv_idle_pct = 23;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      write_reg(sdp_pkg::CFG_SMOOTHING, ph == 5 ? 32'hffff_ffff : $urandom_range(32'h4_0000, 1));
      write_reg(sdp_pkg::CFG_FLUID_MASS, ph == 4 ? 32'd0 : $urandom);
      write_reg(sdp_pkg::CFG_SOLID_MASS, $urandom);
      write_reg(sdp_pkg::CFG_REST_DENSITY, $urandom_range(32'h0100_0000, 1));
      write_reg(sdp_pkg::CFG_STIFFNESS, ph == 3 ? 32'd0 : $urandom);
      write_reg(sdp_pkg::CFG_EXPONENT, $urandom_range(7, 1));
      random_particles(290);
      drain();
    end

    if (errors == 0) begin
      $display("sph_density_pressure_unit test passed");
    end else begin
      $display("sph_density_pressure_unit test failed");
    end
    $finish;
  end
endmodule

// ===== sph_density_pressure_unit.f =====
rtl/sdp_pkg.sv
rtl/sdp_mul.sv
rtl/sdp_div.sv
rtl/sdp_sqrt.sv
rtl/sph_density_pressure_unit.sv
tb/tb.sv
